>>> hw/rtl/vfc_pkg.sv
package vfc_pkg;

    // Grid geometry. The grid is stored as rows of GRID_SIZE bits along x,
    // one row for each (y, z) pair.
    localparam int GRID_SIZE = 32;
    localparam int COORD_W   = 5;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int NCW       = ((IDX_W > COORD_W) ? IDX_W : COORD_W) + 1;
    localparam int ROWS      = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = $clog2(ROWS);
    localparam int VTX_W     = 20;
    localparam int NUM_DIRS  = 6;

    localparam logic [VTX_W-1:0] FACE_STEP = VTX_W'(4);

    // Input mode codes.
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_QUERY   = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Face direction codes, also the bit positions of the open-face mask.
    localparam logic [2:0] DIR_XP = 3'd0;
    localparam logic [2:0] DIR_YP = 3'd1;
    localparam logic [2:0] DIR_XM = 3'd2;
    localparam logic [2:0] DIR_YM = 3'd3;
    localparam logic [2:0] DIR_ZP = 3'd4;
    localparam logic [2:0] DIR_ZM = 3'd5;

    typedef logic [COORD_W-1:0]   t_coord;
    typedef logic [NCW-1:0]       t_ncoord;
    typedef logic [GRID_SIZE-1:0] t_row;
    typedef logic [ADDR_W-1:0]    t_addr;

    typedef struct packed {
        logic [1:0] mode;
        t_coord     x;
        t_coord     y;
        t_coord     z;
        logic       solid;
    } t_in_item;

    typedef struct packed {
        t_coord           face_x;
        t_coord           face_y;
        t_coord           face_z;
        logic [2:0]       direction;
        logic [VTX_W-1:0] vertex_base;
        logic             last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op    op;
        t_coord x;
        t_coord y;
        t_coord z;
        logic   solid;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_RD,
        ST_W_WR,
        ST_Q_RD,
        ST_Q_CAP,
        ST_EMIT
    } t_back_state;

    function automatic logic in_grid(t_ncoord c);
        return c < NCW'(GRID_SIZE);
    endfunction

    function automatic t_addr row_addr(t_ncoord y, t_ncoord z);
        return ADDR_W'(int'(z) * GRID_SIZE + int'(y));
    endfunction

    function automatic logic bit_at(t_row row, t_ncoord c);
        return in_grid(c) && row[c[IDX_W-1:0]];
    endfunction

endpackage

>>> hw/rtl/voxel_face_culler.sv
// A query gives its faces one a cycle while the output register is not held by a stall.
// The back stage runs one command at a time from the front queue: a write reads and
// rewrites one row, a restart clears the vertex counter, a query reads rows and emits faces.
// The single grid RAM port sets the pace: a query reads five grid rows one after another.
// Reset (synchronous, active low) starts a pass that clears all 1024 grid rows to air;
// no item is accepted during that pass. The vertex counter resets to zero.
module voxel_face_culler import vfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    // The front stage takes items off the input channel, drops those that
    // can have no effect (unused mode codes, writes and queries outside the
    // grid), and turns the rest into commands in a two-entry queue. It
    // stalls the input only while the queue is full or the grid is still
    // being cleared after reset.
    //
    // The back stage owns the occupancy grid, held as one row of bits along
    // x for each (y, z) pair in a single-port RAM. A write is a read-modify-
    // write of one row. A query reads the center row, which also gives both
    // x neighbors, and then the four rows above, below, in front and behind.
    // The six open-face bits feed a picker that sends one face record per
    // cycle through an output register while no downstream stall holds it;
    // after the last one is loaded, the back stage can take the next command.

    logic      q_valid;
    t_cmd      q_cmd;
    t_back_ctl back_ctl;

    vfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_ctl     (back_ctl)
    );

    vfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_ctl     (back_ctl),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

>>> hw/rtl/vfc_ram.sv
module vfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/vfc_front.sv
module vfc_front import vfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_q_valid,
    output t_cmd      o_q_cmd,
    input  t_back_ctl i_ctl
);

    t_cmd       cmd;
    logic       keep;
    logic       push;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       grid_ok;

    // Items that cannot change state or give results are dropped here.
    assign grid_ok = in_grid(NCW'(i_item.x)) && in_grid(NCW'(i_item.y))
                     && in_grid(NCW'(i_item.z));

    always_comb begin
        cmd.x     = i_item.x;
        cmd.y     = i_item.y;
        cmd.z     = i_item.z;
        cmd.solid = i_item.solid;
        cmd.op    = OP_WRITE;
        keep      = 1'b0;
        unique case (i_item.mode)
            MODE_WRITE: begin
                cmd.op = OP_WRITE;
                keep   = grid_ok;
            end
            MODE_QUERY: begin
                cmd.op = OP_QUERY;
                keep   = grid_ok;
            end
            MODE_RESTART: begin
                cmd.op = OP_RESTART;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall   = i_ctl.clearing || (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_ctl.pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_ctl.pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/vfc_back.sv
module vfc_back import vfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output t_back_ctl o_ctl,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_back_state      r_state;
    t_back_state      n_state;
    t_cmd             r_cmd;
    t_addr            r_clr;
    logic [2:0]       r_step;
    logic [2:0]       r_pstep;
    logic             r_pend;
    logic             r_ctr;
    logic [5:0]       r_open;
    logic [VTX_W-1:0] r_vtx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             ram_we;
    t_addr            ram_addr;
    t_row             ram_wdata;
    t_row             ram_rdata;
    t_row             wrow;

    t_ncoord          xn, yn, zn, xp, xm, yp, ym, zp, zm;
    t_addr            step_addr;
    logic [5:0]       eff;
    logic [5:0]       sel_hot;
    logic [2:0]       sel;
    logic             can_load;
    logic             load;

    vfc_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Neighbor coordinates carry one extra bit; below zero wraps to all ones,
    // which the bounds test sees as outside the grid.
    assign xn = NCW'(r_cmd.x);
    assign yn = NCW'(r_cmd.y);
    assign zn = NCW'(r_cmd.z);
    assign xp = xn + NCW'(1);
    assign xm = xn - NCW'(1);
    assign yp = yn + NCW'(1);
    assign ym = yn - NCW'(1);
    assign zp = zn + NCW'(1);
    assign zm = zn - NCW'(1);

    always_comb begin
        unique case (r_step)
            3'd0:    step_addr = row_addr(yn, zn);
            3'd1:    step_addr = row_addr(yp, zn);
            3'd2:    step_addr = row_addr(ym, zn);
            3'd3:    step_addr = row_addr(yn, zp);
            3'd4:    step_addr = row_addr(yn, zm);
            default: step_addr = row_addr(yn, zn);
        endcase
    end

    always_comb begin
        wrow                   = ram_rdata;
        wrow[xn[IDX_W-1:0]]    = r_cmd.solid;
    end

    // Face picker: lowest remaining open direction goes out next.
    assign eff = r_open & {6{r_ctr}};

    always_comb begin
        sel = 3'd0;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (eff[i]) begin
                sel = 3'(i);
            end
        end
        sel_hot = 6'd1 << sel;
    end

    assign can_load = !r_out_valid || !i_stall;
    assign load     = (r_state == ST_EMIT) && (eff != 6'd0) && can_load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_WRITE:   n_state = ST_W_RD;
                        OP_QUERY:   n_state = ST_Q_RD;
                        OP_RESTART: n_state = ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_W_RD:  n_state = ST_W_WR;
            ST_W_WR:  n_state = ST_IDLE;
            ST_Q_RD: begin
                if (r_step == 3'd4) begin
                    n_state = ST_Q_CAP;
                end
            end
            ST_Q_CAP: n_state = ST_EMIT;
            ST_EMIT: begin
                if (eff == 6'd0) begin
                    n_state = ST_IDLE;
                end else if (can_load && ((eff & ~sel_hot) == 6'd0)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we         = 1'b0;
        ram_addr       = row_addr(yn, zn);
        ram_wdata      = wrow;
        o_ctl.pop      = 1'b0;
        o_ctl.clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we         = 1'b1;
                ram_addr       = r_clr;
                ram_wdata      = '0;
                o_ctl.clearing = 1'b1;
            end
            ST_IDLE: begin
                o_ctl.pop = i_q_valid;
            end
            ST_W_RD: begin
                ram_addr = row_addr(yn, zn);
            end
            ST_W_WR: begin
                ram_we    = 1'b1;
                ram_addr  = row_addr(yn, zn);
                ram_wdata = wrow;
            end
            ST_Q_RD: begin
                ram_addr = step_addr;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_step      <= 3'd0;
            r_pstep     <= 3'd0;
            r_pend      <= 1'b0;
            r_ctr       <= 1'b0;
            r_open      <= 6'd0;
            r_vtx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_Q_RD);
            r_pstep <= r_step;

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end

            if ((r_state == ST_IDLE) && i_q_valid) begin
                r_cmd  <= i_q_cmd;
                r_step <= 3'd0;
                if (i_q_cmd.op == OP_RESTART) begin
                    r_vtx <= '0;
                end
            end

            if (r_state == ST_Q_RD) begin
                r_step <= r_step + 3'd1;
            end

            if (r_pend) begin
                unique case (r_pstep)
                    3'd0: begin
                        r_ctr          <= bit_at(ram_rdata, xn);
                        r_open[DIR_XP] <= !bit_at(ram_rdata, xp);
                        r_open[DIR_XM] <= !bit_at(ram_rdata, xm);
                    end
                    3'd1: r_open[DIR_YP] <= !(in_grid(yp) && bit_at(ram_rdata, xn));
                    3'd2: r_open[DIR_YM] <= !(in_grid(ym) && bit_at(ram_rdata, xn));
                    3'd3: r_open[DIR_ZP] <= !(in_grid(zp) && bit_at(ram_rdata, xn));
                    3'd4: r_open[DIR_ZM] <= !(in_grid(zm) && bit_at(ram_rdata, xn));
                    default: r_ctr <= r_ctr;
                endcase
            end

            if (load) begin
                r_out_valid       <= 1'b1;
                r_out.face_x      <= r_cmd.x;
                r_out.face_y      <= r_cmd.y;
                r_out.face_z      <= r_cmd.z;
                r_out.direction   <= sel;
                r_out.vertex_base <= r_vtx;
                r_out.last        <= ((eff & ~sel_hot) == 6'd0);
                r_open            <= r_open & ~sel_hot;
                r_vtx             <= r_vtx + FACE_STEP;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

>>> bench/vfc_face_checker.sv
module vfc_face_checker import vfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the grid, indexed (z * GRID_SIZE + y) * GRID_SIZE + x.
    bit [GRID_SIZE*GRID_SIZE*GRID_SIZE-1:0] occupied;
    logic [VTX_W-1:0] vtx_next;
    t_out_item        faces_due[$];
    int               errors;

    function automatic bit solid_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= GRID_SIZE || y >= GRID_SIZE || z >= GRID_SIZE) begin
            return 1'b0;
        end
        return occupied[(z * GRID_SIZE + y) * GRID_SIZE + x];
    endfunction

    function automatic bit solid_beside(int x, int y, int z, logic [2:0] dir);
        case (dir)
            DIR_XP: return solid_at(x + 1, y, z);
            DIR_YP: return solid_at(x, y + 1, z);
            DIR_XM: return solid_at(x - 1, y, z);
            DIR_YM: return solid_at(x, y - 1, z);
            DIR_ZP: return solid_at(x, y, z + 1);
            default: return solid_at(x, y, z - 1);
        endcase
    endfunction

    // Applies one accepted item to the shadow state and queues the faces it exposes.
    task automatic apply_voxel_op(input t_in_item op);
        int x, y, z, total, seen;
        logic [NUM_DIRS-1:0] open_faces;
        t_out_item face;
        x = op.x;
        y = op.y;
        z = op.z;
        case (op.mode)
            MODE_WRITE: begin
                if (x < GRID_SIZE && y < GRID_SIZE && z < GRID_SIZE) begin
                    occupied[(z * GRID_SIZE + y) * GRID_SIZE + x] = op.solid;
                end
            end
            MODE_RESTART: begin
                vtx_next = '0;
            end
            MODE_QUERY: begin
                if (solid_at(x, y, z)) begin
                    total = 0;
                    for (int d = 0; d < NUM_DIRS; d++) begin
                        open_faces[d] = !solid_beside(x, y, z, 3'(d));
                        if (open_faces[d]) total++;
                    end
                    seen = 0;
                    for (int d = 0; d < NUM_DIRS; d++) begin
                        if (open_faces[d]) begin
                            seen++;
                            face.face_x      = op.x;
                            face.face_y      = op.y;
                            face.face_z      = op.z;
                            face.direction   = 3'(d);
                            face.vertex_base = vtx_next;
                            face.last        = (seen == total);
                            faces_due.push_back(face);
                            vtx_next = vtx_next + FACE_STEP;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            occupied = '0;
            vtx_next = '0;
            faces_due.delete();
            errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (faces_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected face: expected none", $time);
                    $display("%0t:   actual x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                             $time, i_out_item.face_x, i_out_item.face_y,
                             i_out_item.face_z, i_out_item.direction,
                             i_out_item.vertex_base, i_out_item.last);
                end else begin
                    want = faces_due.pop_front();
                    if (i_out_item.face_x !== want.face_x || i_out_item.face_y !== want.face_y ||
                        i_out_item.face_z !== want.face_z ||
                        i_out_item.direction !== want.direction ||
                        i_out_item.vertex_base !== want.vertex_base ||
                        i_out_item.last !== want.last) begin
                        errors++;
                        $display("%0t: face mismatch: expected x=%0d y=%0d z=%0d dir=%0d",
                                 $time, want.face_x, want.face_y, want.face_z,
                                 want.direction);
                        $display("%0t:   expected base=%0d last=%0d",
                                 $time, want.vertex_base, want.last);
                        $display("%0t:   actual x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                                 $time, i_out_item.face_x, i_out_item.face_y,
                                 i_out_item.face_z, i_out_item.direction,
                                 i_out_item.vertex_base, i_out_item.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_voxel_op(i_in_item);
            end
        end
        o_fail_count <= errors;
        o_pending    <= faces_due.size();
    end

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vfc_pkg::*;

    localparam int GMAX         = GRID_SIZE - 1;
    localparam int RESET_CYCLES = 6;
    // Long enough for the block to fill up completely while faces are held off.
    localparam int HOLD_CYCLES  = 300;
    // Both the clearing pass after reset, in which nothing is accepted, and the long
    // receiver hold-off leave the channels idle; this limit leaves ample margin over both.
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 24;
    localparam int RANDOM_OPS   = 120;
    // Back-to-back queries of a voxel with all six faces open at the end of the run.
    localparam int FINAL_QUERIES = 4;
    // The one mode code the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    int fail_count;
    int pending;

    // Sender and receiver pacing state shared between the processes below.
    bit sending     = 1'b0;
    int burst_left  = 1;
    bit no_gaps     = 1'b0;
    int rx_style    = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    voxel_face_culler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    vfc_face_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item voxel_op(logic [1:0] mode, int x, int y, int z, logic solid);
        t_in_item op;
        op.mode  = mode;
        op.x     = t_coord'(x);
        op.y     = t_coord'(y);
        op.z     = t_coord'(z);
        op.solid = solid;
        return op;
    endfunction

    // Corner of a 3x3x3 cluster: the grid faces are favored so that neighbors
    // outside the grid come up often, the rest of the grid still gets visited.
    function automatic int pick_corner();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return GRID_SIZE - 3;
            default: return $urandom_range(0, GRID_SIZE - 3);
        endcase
    endfunction

    function automatic int near(int corner);
        return corner + $urandom_range(0, 2);
    endfunction

    // Offers one item and returns at the clock edge where the block takes it. Valid stays
    // high from one item to the next inside a burst; between bursts it drops for a random
    // gap, unless gaps are switched off for a stretch.
    task automatic send_op(input t_in_item op);
        int gap;
        i_valid <= 1'b1;
        i_item  <= op;
        sending = 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                sending = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops offering items and waits until every predicted face has come out. The first
    // edge lets the checker take in the item accepted at the current edge.
    task automatic drain_faces();
        if (sending) begin
            i_valid <= 1'b0;
            sending = 1'b0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: stalls in runs of random length whose density depends on rx_style, and
    // serves a long hold-off whenever the stimulus asks for one.
    initial begin : face_sink
        int run_left;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (holds_asked != holds_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                holds_done++;
                run_left = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                run_left = $urandom_range(1, 6);
                case (rx_style)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("voxel_face_culler verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int  ops_sent;
        int  cx, cy, cz, n, mode_pick;
        bit  held, drained;
        ops_sent = 0;
        held     = 1'b0;
        drained  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first items wait out the clearing pass behind o_stall.
        // An air voxel gives no faces.
        send_op(voxel_op(MODE_QUERY, 0, 0, 0, 1'b0));
        // A lone voxel in a corner: all six faces, three of them against the grid edge.
        send_op(voxel_op(MODE_WRITE, 0, 0, 0, 1'b1));
        send_op(voxel_op(MODE_QUERY, 0, 0, 0, 1'b0));
        // The opposite corner, with the solid bit set on the query, where it means nothing.
        send_op(voxel_op(MODE_WRITE, GMAX, GMAX, GMAX, 1'b1));
        send_op(voxel_op(MODE_QUERY, GMAX, GMAX, GMAX, 1'b1));
        // Covering the +x neighbor removes that face only.
        send_op(voxel_op(MODE_WRITE, 1, 0, 0, 1'b1));
        send_op(voxel_op(MODE_QUERY, 0, 0, 0, 1'b0));
        // With +y and +z covered too, only the faces outside the grid remain.
        send_op(voxel_op(MODE_WRITE, 0, 1, 0, 1'b1));
        send_op(voxel_op(MODE_WRITE, 0, 0, 1, 1'b1));
        send_op(voxel_op(MODE_QUERY, 0, 0, 0, 1'b0));
        // Restart the vertex counter; the other fields carry no meaning here.
        send_op(voxel_op(MODE_RESTART, GMAX, GMAX, GMAX, 1'b1));
        send_op(voxel_op(MODE_QUERY, 1, 0, 0, 1'b0));
        // The unused mode must not act as a write: (2,0,0) stays air, so the query
        // of (1,0,0) still shows its +x face.
        send_op(voxel_op(MODE_UNUSED, 2, 0, 0, 1'b1));
        send_op(voxel_op(MODE_QUERY, 1, 0, 0, 1'b0));
        // Writing air clears a voxel again.
        send_op(voxel_op(MODE_WRITE, 0, 0, 0, 1'b0));
        send_op(voxel_op(MODE_QUERY, 0, 0, 0, 1'b1));
        // A voxel buried on all six sides gives nothing; one of its neighbors gives five.
        send_op(voxel_op(MODE_WRITE, 2, 2, 2, 1'b1));
        send_op(voxel_op(MODE_WRITE, 3, 2, 2, 1'b1));
        send_op(voxel_op(MODE_WRITE, 1, 2, 2, 1'b1));
        send_op(voxel_op(MODE_WRITE, 2, 3, 2, 1'b1));
        send_op(voxel_op(MODE_WRITE, 2, 1, 2, 1'b1));
        send_op(voxel_op(MODE_WRITE, 2, 2, 3, 1'b1));
        send_op(voxel_op(MODE_WRITE, 2, 2, 1, 1'b1));
        send_op(voxel_op(MODE_QUERY, 2, 2, 2, 1'b0));
        send_op(voxel_op(MODE_QUERY, 3, 2, 2, 1'b0));

        // Random part: each round builds a small cluster of mostly solid voxels and then
        // queries inside it, so that queries see every mix of open and covered faces.
        // Some rounds add a stray item anywhere in the grid, unused mode included.
        while (ops_sent < RANDOM_OPS) begin
            cx = pick_corner();
            cy = pick_corner();
            cz = pick_corner();
            no_gaps  = ($urandom_range(0, 3) == 0);
            rx_style = no_gaps ? 0 : $urandom_range(0, 2);

            n = $urandom_range(2, 8);
            repeat (n) begin
                send_op(voxel_op(MODE_WRITE, near(cx), near(cy), near(cz),
                                 $urandom_range(0, 3) != 0));
                ops_sent++;
            end
            n = $urandom_range(1, 5);
            repeat (n) begin
                send_op(voxel_op(MODE_QUERY, near(cx), near(cy), near(cz), $urandom_range(0, 1)));
                ops_sent++;
            end

            if ($urandom_range(0, 2) == 0) begin
                mode_pick = $urandom_range(0, 3);
                send_op(voxel_op(2'(mode_pick), $urandom_range(0, GMAX), $urandom_range(0, GMAX),
                                 $urandom_range(0, GMAX), $urandom_range(0, 1)));
                if (2'(mode_pick) != MODE_UNUSED) ops_sent++;
            end

            // Once: the receiver holds off for a long stretch while a run of queries on a
            // solid corner voxel keeps coming. Its three faces against the grid edge are
            // always open, so the block fills and stalls its input.
            if (!held && ops_sent >= 60) begin
                held = 1'b1;
                send_op(voxel_op(MODE_WRITE, 0, 0, 0, 1'b1));
                ops_sent++;
                holds_asked++;
                repeat (16) begin
                    send_op(voxel_op(MODE_QUERY, 0, 0, 0, 1'b0));
                    ops_sent++;
                end
            end

            // Once: the sender pauses until every face has come out.
            if (!drained && ops_sent >= 110) begin
                drained = 1'b1;
                drain_faces();
            end
        end

        // A lone voxel with all six faces open, queried back to back with no idling on
        // either side.
        drain_faces();
        no_gaps  = 1'b1;
        rx_style = 0;
        send_op(voxel_op(MODE_RESTART, 0, 0, 0, 1'b0));
        send_op(voxel_op(MODE_WRITE, GMAX - 1, GMAX, GMAX, 1'b0));
        send_op(voxel_op(MODE_WRITE, GMAX, GMAX - 1, GMAX, 1'b0));
        send_op(voxel_op(MODE_WRITE, GMAX, GMAX, GMAX - 1, 1'b0));
        send_op(voxel_op(MODE_WRITE, GMAX, GMAX, GMAX, 1'b1));
        repeat (FINAL_QUERIES) send_op(voxel_op(MODE_QUERY, GMAX, GMAX, GMAX, 1'b0));

        // Wait for the last faces, then a few more cycles to catch any stray output.
        drain_faces();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("voxel_face_culler verification clean");
        end else begin
            $display("voxel_face_culler verification failed");
        end
        $finish;
    end

endmodule
